@@ rtl/buddy_page_allocator_macros.svh @@
// Assertion shorthands used by the checker file of the page allocator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps

package bpa_pkg;

    typedef logic [1:0]  t_mode;
    typedef logic [3:0]  t_order;
    typedef logic [15:0] t_page;
    typedef logic [16:0] t_count;
    typedef logic [1:0]  t_status;

    localparam t_mode MODE_ALLOC   = 2'd0;
    localparam t_mode MODE_FREE    = 2'd1;
    localparam t_mode MODE_ADD     = 2'd2;
    localparam t_mode MODE_RESERVE = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NO_FREE = 2'd1;
    localparam t_status ST_BAD_ARG = 2'd2;
    localparam t_status ST_NOT_FREE = 2'd3;

    // The free bitmap is stored in words of 64 page bits.
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_map_ctl;

endpackage

@@ rtl/bpa_if.sv @@
`timescale 1ns / 1ps

interface bpa_req_if;
    import bpa_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  mode;
    t_order order;
    t_page  page_number;
    t_count page_count;

    modport source (output valid, mode, order, page_number, page_count, input ready);
    modport sink   (input valid, mode, order, page_number, page_count, output ready);
endinterface

interface bpa_rsp_if;
    import bpa_pkg::*;

    logic    valid;
    logic    ready;
    t_page   page_number_res;
    t_status status;

    modport source (output valid, page_number_res, status, input ready);
    modport sink   (input valid, page_number_res, status, output ready);
endinterface

@@ rtl/bpa_bitmap.sv @@
`timescale 1ns / 1ps

module bpa_bitmap #(
    parameter int AW = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bpa_pkg::t_map_ctl    i_ctl,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  bpa_pkg::t_word       i_wr_data,
    output bpa_pkg::t_word       o_rd_data,
    output logic                 o_busy
);
    import bpa_pkg::*;

    t_word          r_mem [2**AW];
    t_word          r_rd_data;
    logic           r_clr_busy;
    logic [AW-1:0]  r_clr_addr;

    // After reset every word is swept to zero, one word per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

@@ rtl/buddy_page_allocator.sv @@
`timescale 1ns / 1ps
// Allocate scans the bitmap words of each order from the one requested upward,
// then claims the block found and hands back a half per split before posting the result.
// Free, add and reserve take a step, a read and an optional write-back per bitmap bit touched.
// Throughput: one transfer at a time; ready stays low until the result is posted.
// Reset: after i_rst_n every bitmap word is cleared in a sweep;
// no request is taken during that sweep.
module buddy_page_allocator #(
    parameter int TOP_ORDER       = 10,
    parameter int PAGE_INDEX_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpa_req_if.sink       i_req,
    bpa_rsp_if.source     o_rsp
);
    import bpa_pkg::*;

    // Address of a bitmap word is {order, page[PX-1:6]}. Very small page spaces are
    // padded up to two words per order; pages beyond the space are never set.
    localparam int OB  = $clog2(TOP_ORDER + 1);
    localparam int KW  = $clog2(TOP_ORDER + 2);
    localparam int PX  = (PAGE_INDEX_BITS > 7) ? PAGE_INDEX_BITS : 7;
    localparam int WIB = PX - BIT_W;
    localparam int AW  = OB + WIB;
    localparam int PW  = ((PAGE_INDEX_BITS > 18) ? PAGE_INDEX_BITS : 18) + 2;

    localparam logic [PW-1:0] SPACE = {{(PW-1){1'b0}}, 1'b1} << PAGE_INDEX_BITS;
    localparam logic [KW-1:0] MAXK  = KW'(TOP_ORDER);
    localparam logic [WIB:0]  NW    = {1'b1, {WIB{1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_AL_SPLIT,
        S_FR_CHK, S_FR_GOT, S_FR_CLRB, S_FR_UP,
        S_AD_K, S_AD_NEXT,
        S_RS_Q, S_RS_LOOK, S_RS_GOT, S_RS_SPLIT,
        S_ACC_RD, S_ACC_DO, S_DONE
    } t_state;

    function automatic logic [PW-1:0] f_pow(input logic [KW-1:0] k);
        f_pow = {{(PW-1){1'b0}}, 1'b1} << k;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [KW-1:0] k, input logic [PW-1:0] p);
        f_addr = {k[OB-1:0], p[PX-1:BIT_W]};
    endfunction

    // Lowest set bit of a bitmap word.
    function automatic logic [BIT_W-1:0] f_ffs(input t_word w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = BIT_W'(i);
            end
        end
        f_ffs = r;
    endfunction

    t_state          r_state;
    t_state          r_ret;
    logic [KW-1:0]   r_k;
    logic [KW-1:0]   r_x;
    logic [KW-1:0]   r_j;
    logic [PW-1:0]   r_p;
    logic [PW-1:0]   r_b;
    logic [PW-1:0]   r_q;
    logic [PW-1:0]   r_n;
    logic [WIB:0]    r_w;
    logic [WIB-1:0]  r_wp;
    logic            r_sv;
    logic [KW-1:0]   r_acc_k;
    logic [PW-1:0]   r_acc_p;
    logic            r_acc_wr;
    logic            r_acc_val;
    logic            r_bit;
    t_page           r_res;
    t_status         r_status;
    logic            r_out_valid;
    t_page           r_out_page;
    t_status         r_out_status;

    t_map_ctl        w_ctl;
    logic [AW-1:0]   w_rd_addr;
    logic [AW-1:0]   w_wr_addr;
    t_word           w_wr_data;
    t_word           w_rd_data;
    logic            w_busy;
    logic            w_in_ready;

    // Request decode, evaluated on the incoming payload.
    logic [KW-1:0]   w_in_k;
    logic [PW-1:0]   w_in_p;
    logic [PW-1:0]   w_in_n;
    logic [PW-1:0]   w_in_size;
    logic [PW-1:0]   w_in_room;
    logic            w_bad_order;
    logic            w_page_bad;
    logic            w_free_bad;

    // Shared per-step arithmetic.
    logic [PW-1:0]   w_pow_k;
    logic [PW-1:0]   w_pow_x;
    logic [PW-1:0]   w_pow_j1;
    logic [PW-1:0]   w_buddy;
    logic [PW-1:0]   w_found_p;

    assign w_in_k      = KW'(i_req.order);
    assign w_in_p      = {{(PW-16){1'b0}}, i_req.page_number};
    assign w_in_n      = {{(PW-17){1'b0}}, i_req.page_count};
    assign w_in_size   = f_pow(w_in_k);
    assign w_in_room   = SPACE - w_in_p;
    assign w_bad_order = ({28'd0, i_req.order} > 32'(TOP_ORDER));
    assign w_page_bad  = (w_in_p >= SPACE);
    assign w_free_bad  = w_bad_order || ((w_in_p & (w_in_size - 1'b1)) != '0)
                         || ((w_in_p + w_in_size) > SPACE);

    assign w_pow_k   = f_pow(r_k);
    assign w_pow_x   = f_pow(r_x);
    assign w_pow_j1  = f_pow(r_j - 1'b1);
    assign w_buddy   = r_p ^ w_pow_k;
    assign w_found_p = {{(PW-PX){1'b0}}, r_wp, f_ffs(w_rd_data)};

    assign w_in_ready  = (r_state == S_IDLE) && !w_busy;
    assign i_req.ready = w_in_ready;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.page_number_res = r_out_page;
    assign o_rsp.status          = r_out_status;

    // Bitmap port steering: the scan streams one word per cycle, every other
    // access is a read followed by an optional write of the same word.
    always_comb begin
        w_ctl.rd_en = 1'b0;
        w_ctl.wr_en = 1'b0;
        w_rd_addr   = f_addr(r_acc_k, r_acc_p);
        w_wr_addr   = f_addr(r_acc_k, r_acc_p);
        w_wr_data   = w_rd_data;
        w_wr_data[r_acc_p[BIT_W-1:0]] = r_acc_val;
        if (r_state == S_SCAN) begin
            w_ctl.rd_en = 1'b1;
            w_rd_addr   = {r_x[OB-1:0], r_w[WIB-1:0]};
        end
        if (r_state == S_ACC_RD) begin
            w_ctl.rd_en = 1'b1;
        end
        if (r_state == S_ACC_DO && r_acc_wr) begin
            w_ctl.wr_en = 1'b1;
        end
    end

    bpa_bitmap #(
        .AW (AW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data),
        .o_busy    (w_busy)
    );

    // Sequencer. Each bitmap bit access jumps through S_ACC_RD and S_ACC_DO and
    // comes back to the state held in r_ret.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE drives the valid flag itself in the cycle it posts a result.
            if (r_out_valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && w_in_ready) begin
                        r_k      <= w_in_k;
                        r_x      <= w_in_k;
                        r_p      <= w_in_p;
                        r_res    <= '0;
                        r_status <= ST_OK;
                        unique case (i_req.mode)
                            MODE_ALLOC: begin
                                if (w_bad_order) begin
                                    r_status <= ST_BAD_ARG;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_w     <= '0;
                                    r_sv    <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            MODE_FREE: begin
                                if (w_free_bad) begin
                                    r_status <= ST_BAD_ARG;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_acc_k   <= w_in_k;
                                    r_acc_p   <= w_in_p;
                                    r_acc_wr  <= 1'b1;
                                    r_acc_val <= 1'b1;
                                    r_ret     <= S_FR_CHK;
                                    r_state   <= S_ACC_RD;
                                end
                            end
                            MODE_ADD: begin
                                if (w_page_bad) begin
                                    r_status <= ST_BAD_ARG;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_n     <= (w_in_n < w_in_room) ? w_in_n : w_in_room;
                                    r_k     <= MAXK;
                                    r_state <= S_AD_K;
                                end
                            end
                            MODE_RESERVE: begin
                                if (w_page_bad) begin
                                    r_status <= ST_BAD_ARG;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_q     <= w_in_p;
                                    r_n     <= w_in_n;
                                    r_state <= S_RS_Q;
                                end
                            end
                        endcase
                    end
                end

                // Stream the words of order r_x; the word read last cycle is checked.
                S_SCAN: begin
                    if (r_sv && w_rd_data != '0) begin
                        r_p       <= w_found_p;
                        r_j       <= r_x;
                        r_acc_k   <= r_x;
                        r_acc_p   <= w_found_p;
                        r_acc_wr  <= 1'b1;
                        r_acc_val <= 1'b0;
                        r_ret     <= S_AL_SPLIT;
                        r_state   <= S_ACC_RD;
                    end else if (r_w == NW) begin
                        if (r_x == MAXK) begin
                            r_status <= ST_NO_FREE;
                            r_state  <= S_DONE;
                        end else begin
                            r_x  <= r_x + 1'b1;
                            r_w  <= '0;
                            r_sv <= 1'b0;
                        end
                    end else begin
                        r_wp <= r_w[WIB-1:0];
                        r_w  <= r_w + 1'b1;
                        r_sv <= 1'b1;
                    end
                end

                // Hand back the right half at each order down to the one requested.
                S_AL_SPLIT: begin
                    if (r_j > r_k) begin
                        r_j       <= r_j - 1'b1;
                        r_acc_k   <= r_j - 1'b1;
                        r_acc_p   <= r_p + w_pow_j1;
                        r_acc_wr  <= 1'b1;
                        r_acc_val <= 1'b1;
                        r_ret     <= S_AL_SPLIT;
                        r_state   <= S_ACC_RD;
                    end else begin
                        r_res   <= r_p[15:0];
                        r_state <= S_DONE;
                    end
                end

                S_FR_CHK: begin
                    if (r_k == MAXK || (w_buddy + w_pow_k) > SPACE) begin
                        r_state <= S_DONE;
                    end else begin
                        r_b       <= w_buddy;
                        r_acc_k   <= r_k;
                        r_acc_p   <= w_buddy;
                        r_acc_wr  <= 1'b0;
                        r_acc_val <= 1'b0;
                        r_ret     <= S_FR_GOT;
                        r_state   <= S_ACC_RD;
                    end
                end

                S_FR_GOT: begin
                    if (!r_bit) begin
                        r_state <= S_DONE;
                    end else begin
                        r_acc_k   <= r_k;
                        r_acc_p   <= r_p;
                        r_acc_wr  <= 1'b1;
                        r_acc_val <= 1'b0;
                        r_ret     <= S_FR_CLRB;
                        r_state   <= S_ACC_RD;
                    end
                end

                S_FR_CLRB: begin
                    r_acc_k   <= r_k;
                    r_acc_p   <= r_b;
                    r_acc_wr  <= 1'b1;
                    r_acc_val <= 1'b0;
                    r_ret     <= S_FR_UP;
                    r_state   <= S_ACC_RD;
                end

                // Merged pair becomes one block of the next order.
                S_FR_UP: begin
                    r_p       <= r_p & ~w_pow_k;
                    r_k       <= r_k + 1'b1;
                    r_acc_k   <= r_k + 1'b1;
                    r_acc_p   <= r_p & ~w_pow_k;
                    r_acc_wr  <= 1'b1;
                    r_acc_val <= 1'b1;
                    r_ret     <= S_FR_CHK;
                    r_state   <= S_ACC_RD;
                end

                // Step the order down until an aligned block fits in what is left.
                S_AD_K: begin
                    if (r_n == '0) begin
                        r_state <= S_DONE;
                    end else if (r_k != '0 && (((r_p & (w_pow_k - 1'b1)) != '0)
                                               || r_n < w_pow_k)) begin
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_acc_k   <= r_k;
                        r_acc_p   <= r_p;
                        r_acc_wr  <= 1'b1;
                        r_acc_val <= 1'b1;
                        r_ret     <= S_AD_NEXT;
                        r_state   <= S_ACC_RD;
                    end
                end

                S_AD_NEXT: begin
                    r_p     <= r_p + w_pow_k;
                    r_n     <= r_n - w_pow_k;
                    r_k     <= MAXK;
                    r_state <= S_AD_K;
                end

                S_RS_Q: begin
                    if (r_n == '0) begin
                        r_state <= S_DONE;
                    end else if (r_q >= SPACE) begin
                        r_status <= ST_NOT_FREE;
                        r_state  <= S_DONE;
                    end else begin
                        r_x     <= '0;
                        r_state <= S_RS_LOOK;
                    end
                end

                // Probe orders upward for the free block that holds page r_q.
                S_RS_LOOK: begin
                    if (r_x > MAXK) begin
                        r_status <= ST_NOT_FREE;
                        r_state  <= S_DONE;
                    end else begin
                        r_b       <= r_q & ~(w_pow_x - 1'b1);
                        r_acc_k   <= r_x;
                        r_acc_p   <= r_q & ~(w_pow_x - 1'b1);
                        r_acc_wr  <= 1'b0;
                        r_acc_val <= 1'b0;
                        r_ret     <= S_RS_GOT;
                        r_state   <= S_ACC_RD;
                    end
                end

                S_RS_GOT: begin
                    if (!r_bit) begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_RS_LOOK;
                    end else begin
                        r_j       <= r_x;
                        r_acc_k   <= r_x;
                        r_acc_p   <= r_b;
                        r_acc_wr  <= 1'b1;
                        r_acc_val <= 1'b0;
                        r_ret     <= S_RS_SPLIT;
                        r_state   <= S_ACC_RD;
                    end
                end

                // Halve toward the page, freeing the half that does not hold it.
                S_RS_SPLIT: begin
                    if (r_j != '0) begin
                        r_j       <= r_j - 1'b1;
                        r_acc_k   <= r_j - 1'b1;
                        r_acc_wr  <= 1'b1;
                        r_acc_val <= 1'b1;
                        r_ret     <= S_RS_SPLIT;
                        r_state   <= S_ACC_RD;
                        if (r_q >= r_b + w_pow_j1) begin
                            r_acc_p <= r_b;
                            r_b     <= r_b + w_pow_j1;
                        end else begin
                            r_acc_p <= r_b + w_pow_j1;
                        end
                    end else begin
                        r_q     <= r_q + 1'b1;
                        r_n     <= r_n - 1'b1;
                        r_state <= S_RS_Q;
                    end
                end

                S_ACC_RD: begin
                    r_state <= S_ACC_DO;
                end

                S_ACC_DO: begin
                    r_bit   <= w_rd_data[r_acc_p[BIT_W-1:0]];
                    r_state <= r_ret;
                end

                // Wait for the output register to free up, then post the result.
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_page   <= r_res;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/bpa_checker.sv @@
`timescale 1ns / 1ps
`include "buddy_page_allocator_macros.svh"

module bpa_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input bpa_pkg::t_page   i_rsp_page,
    input bpa_pkg::t_status i_rsp_status
);
    import bpa_pkg::*;

    // Requests taken whose result has not yet been transferred.
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, (i_req_valid && i_req_ready)}
                           - {1'b0, (i_rsp_valid && i_rsp_ready)};
        end
    end

    `BPA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_page) && $stable(i_rsp_status), "stalled result changed")
    `BPA_ASSERT_NOW(a_rsp_has_req, i_rsp_valid, r_cnt != 2'd0, "result without a pending request")
    `BPA_ASSERT_NOW(a_pending_bound, 1'b1, r_cnt != 2'd3, "too many requests in flight")
    `BPA_ASSERT_NOW(a_fail_page_zero, i_rsp_valid && i_rsp_status != ST_OK, i_rsp_page == '0, "failed result carries a page")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_page   (o_rsp.page_number_res),
    .i_rsp_status (o_rsp.status)
);

@@ tb/buddy_page_allocator_tb.sv @@
`timescale 1ns / 1ps

module buddy_page_allocator_tb;
    import bpa_pkg::*;

    // Page space and order range of the default build of the allocator.
    localparam int TOP_ORDER  = 10;
    localparam int SPACE      = 65536;
    // Cycles without any transfer before the run is declared hung.  The
    // clearing sweep after reset and the slowest allocate scan both fit well
    // inside it.
    localparam int HANG_LIMIT = 200000;
    localparam int RAND_ITEMS = 450;
    localparam int DRAIN_CYC  = 64;

    typedef struct {
        t_mode   mode;
        t_order  order;
        t_page   page;
        t_count  count;
        bit      typed;
        t_page   want_page;
        t_status want_status;
    } t_stim_row;

    typedef struct {
        t_page   page;
        t_status status;
    } t_alloc_result;

    typedef struct {
        int order;
        int page;
    } t_live_block;

    logic i_clk;
    logic i_rst_n;

    bpa_req_if req_if ();
    bpa_rsp_if rsp_if ();

    buddy_page_allocator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Own copy of the free lists: one sparse set of start pages per order.
    bit free_set [0:TOP_ORDER][int];

    t_alloc_result result_q[$];
    t_live_block   live_q[$];
    t_stim_row     rows[$];

    int mismatches;
    int rsp_seen;
    int req_sent;
    int idle_cycles;
    int burst_left;
    int alloc_ok;
    int alloc_fail;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor of the allocator state and of each response.
    // ------------------------------------------------------------------
    function automatic bit is_free(int k, int p);
        return free_set[k].exists(p);
    endfunction

    function automatic void set_free(int k, int p, bit v);
        if (v) begin
            free_set[k][p] = 1'b1;
        end else begin
            free_set[k].delete(p);
        end
    endfunction

    // Lowest free block of the smallest order at or above k; the left half
    // is kept on every split and the right halves go back on the lists.
    function automatic t_status take_block(int k, output int start);
        int x;
        int p;
        bit hit;
        start = 0;
        hit = 1'b0;
        if (k > TOP_ORDER) return ST_BAD_ARG;
        for (x = k; x <= TOP_ORDER; x++) begin
            if (free_set[x].first(p)) begin
                hit = 1'b1;
                break;
            end
        end
        if (!hit) return ST_NO_FREE;
        set_free(x, p, 1'b0);
        for (int j = x; j > k; j--) set_free(j - 1, p + (1 << (j - 1)), 1'b1);
        start = p;
        return ST_OK;
    endfunction

    // No double-free check is made: the bit is set and buddies merge upward.
    function automatic t_status give_block(int k, int p);
        int size;
        int b;
        if (k > TOP_ORDER) return ST_BAD_ARG;
        size = 1 << k;
        if ((p & (size - 1)) != 0 || p + size > SPACE) return ST_BAD_ARG;
        set_free(k, p, 1'b1);
        while (k < TOP_ORDER) begin
            size = 1 << k;
            b = p ^ size;
            if (b + size > SPACE || !is_free(k, b)) break;
            set_free(k, p, 1'b0);
            set_free(k, b, 1'b0);
            p = p & ~size;
            k++;
            set_free(k, p, 1'b1);
        end
        return ST_OK;
    endfunction

    // Largest aligned blocks that fit, without merging; pages past the end
    // of the space are dropped.
    function automatic t_status add_span(int p, int cnt);
        int n;
        int k;
        n = SPACE - p;
        if (cnt < n) n = cnt;
        while (n > 0) begin
            k = TOP_ORDER;
            while (k > 0 && ((p & ((1 << k) - 1)) != 0 || n < (1 << k))) k--;
            set_free(k, p, 1'b1);
            p += 1 << k;
            n -= 1 << k;
        end
        return ST_OK;
    endfunction

    // Page by page: split the block holding the page down to the page itself.
    // Pages reserved before a failing page stay reserved.
    function automatic t_status reserve_span(int start, int cnt);
        int q;
        int x;
        int b;
        int half;
        for (int i = 0; i < cnt; i++) begin
            q = start + i;
            if (q >= SPACE) return ST_NOT_FREE;
            b = 0;
            for (x = 0; x <= TOP_ORDER; x++) begin
                b = q & ~((1 << x) - 1);
                if (is_free(x, b)) break;
            end
            if (x > TOP_ORDER) return ST_NOT_FREE;
            set_free(x, b, 1'b0);
            for (int j = x; j > 0; j--) begin
                half = 1 << (j - 1);
                if (q >= b + half) begin
                    set_free(j - 1, b, 1'b1);
                    b += half;
                end else begin
                    set_free(j - 1, b + half, 1'b1);
                end
            end
        end
        return ST_OK;
    endfunction

    function automatic t_alloc_result predict_response(t_stim_row r);
        t_alloc_result res;
        int start;
        res.page = '0;
        case (r.mode)
            MODE_ALLOC: begin
                res.status = take_block(int'(r.order), start);
                if (res.status == ST_OK) begin
                    res.page = t_page'(start);
                    live_q.push_back('{int'(r.order), start});
                    alloc_ok++;
                end else begin
                    alloc_fail++;
                end
            end
            MODE_FREE:   res.status = give_block(int'(r.order), int'(r.page));
            MODE_ADD:    res.status = add_span(int'(r.page), int'(r.count));
            default:     res.status = reserve_span(int'(r.page), int'(r.count));
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side.  The sender works in bursts; between bursts valid may drop
    // for a random gap.  Ready is sampled at the falling edge,
    // so a high ready there means the transfer completes at the next rising
    // edge, where the next request (or idle) is driven.
    // ------------------------------------------------------------------
    task automatic send_request(t_stim_row r);
        t_alloc_result res;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid       <= 1'b1;
        req_if.mode        <= r.mode;
        req_if.order       <= r.order;
        req_if.page_number <= r.page;
        req_if.page_count  <= r.count;
        do @(negedge i_clk); while (!req_if.ready);
        res = predict_response(r);
        if (r.typed) begin
            res.page   = r.want_page;
            res.status = r.want_status;
        end
        result_q.push_back(res);
        req_sent++;
        @(posedge i_clk);
    endtask

    function automatic void add_row(t_mode m, int o, int p, int c,
                                    bit typed = 1'b0, int wp = 0,
                                    t_status ws = ST_OK);
        t_stim_row r;
        r.mode        = m;
        r.order       = t_order'(o);
        r.page        = t_page'(p);
        r.count       = t_count'(c);
        r.typed       = typed;
        r.want_page   = t_page'(wp);
        r.want_status = ws;
        rows.push_back(r);
    endfunction

    function automatic t_stim_row random_row();
        t_stim_row r;
        t_live_block blk;
        int pick;
        int idx;
        r.typed = 1'b0;
        r.want_page = '0;
        r.want_status = ST_OK;
        r.order = '0;
        r.page = '0;
        r.count = '0;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            r.mode  = MODE_ALLOC;
            r.order = ($urandom_range(0, 19) == 0) ? t_order'($urandom_range(11, 15))
                                                  : t_order'($urandom_range(0, 6));
            if ($urandom_range(0, 9) == 0) r.order = t_order'($urandom_range(7, 10));
            r.page  = t_page'($urandom);
            r.count = t_count'($urandom);
        end else if (pick < 52 && live_q.size() > 0) begin
            // Give back a block that was handed out earlier.
            idx = $urandom_range(0, live_q.size() - 1);
            blk = live_q[idx];
            live_q.delete(idx);
            r.mode  = MODE_FREE;
            r.order = t_order'(blk.order);
            r.page  = t_page'(blk.page);
        end else if (pick < 62) begin
            // Noise: arbitrary order and start, mostly misaligned or illegal.
            r.mode  = MODE_FREE;
            r.order = t_order'($urandom_range(0, 15));
            r.page  = t_page'($urandom);
        end else if (pick < 82) begin
            r.mode  = MODE_ADD;
            r.page  = t_page'($urandom);
            r.count = ($urandom_range(0, 7) == 0) ? t_count'($urandom)
                                                  : t_count'($urandom_range(0, 300));
        end else begin
            // Reserve stays short: each page costs a bitmap walk in the block.
            r.mode  = MODE_RESERVE;
            r.page  = t_page'($urandom);
            if (live_q.size() > 0 && $urandom_range(0, 1) == 0) begin
                blk = live_q[$urandom_range(0, live_q.size() - 1)];
                r.page = t_page'(blk.page + (1 << blk.order));
            end
            r.count = t_count'($urandom_range(0, 12));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response side: ready stalls on a rotating pattern that is reloaded
    // now and then, with long stretches of constant ready in between.
    // ------------------------------------------------------------------
    logic [12:0] stall_pattern;
    int          pattern_age;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_pattern <= 13'h1A5B;
            pattern_age   <= 0;
            rsp_if.ready  <= 1'b0;
        end else begin
            if (pattern_age == 150) begin
                stall_pattern <= ($urandom_range(0, 2) == 0) ? '1 : 13'($urandom);
                pattern_age   <= 0;
            end else begin
                stall_pattern <= {stall_pattern[11:0], stall_pattern[12]};
                pattern_age   <= pattern_age + 1;
            end
            rsp_if.ready <= stall_pattern[0];
        end
    end

    // Compare every response transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected response page=%0d status=%0d",
                             $realtime, rsp_if.page_number_res, rsp_if.status);
            end else begin
                want = result_q.pop_front();
                if (rsp_if.page_number_res !== want.page || rsp_if.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] response %0d: expected page=%0d status=%0d, got page=%0d status=%0d",
                                 $realtime, rsp_seen, want.page, want.status,
                                 rsp_if.page_number_res, rsp_if.status);
                end
            end
        end
    end

    // Hang detector: counts cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", HANG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int drain;
        mismatches = 0;
        rsp_seen   = 0;
        req_sent   = 0;
        burst_left = 0;
        alloc_ok   = 0;
        alloc_fail = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        req_if.valid       <= 1'b0;
        req_if.mode        <= MODE_ALLOC;
        req_if.order       <= '0;
        req_if.page_number <= '0;
        req_if.page_count  <= '0;

        // Directed part.  Results that follow at once from the rules are
        // typed in; the rest is left to the predictor.
        add_row(MODE_ALLOC,   0, 0, 0, 1, 0, ST_NO_FREE);       // empty pool
        add_row(MODE_ALLOC,  11, 0, 0, 1, 0, ST_BAD_ARG);       // order past top
        add_row(MODE_ALLOC,  15, 16'hFFFF, 17'h1FFFF, 1, 0, ST_BAD_ARG);
        add_row(MODE_FREE,   11, 0, 0, 1, 0, ST_BAD_ARG);
        add_row(MODE_FREE,    3, 5, 0, 1, 0, ST_BAD_ARG);       // misaligned
        add_row(MODE_RESERVE, 0, 0, 65536, 1, 0, ST_NOT_FREE);  // nothing free
        add_row(MODE_RESERVE, 0, 0, 0, 1, 0, ST_OK);            // zero count
        add_row(MODE_ADD,     0, 0, 0, 1, 0, ST_OK);
        add_row(MODE_ADD,     0, 0, 65536, 1, 0, ST_OK);        // whole space
        add_row(MODE_ALLOC,  10, 0, 0, 1, 0, ST_OK);
        add_row(MODE_ALLOC,   0, 0, 0, 1, 1024, ST_OK);         // splits the next top block
        add_row(MODE_ALLOC,   9, 0, 0, 1, 1536, ST_OK);
        add_row(MODE_FREE,    0, 1024, 0);
        add_row(MODE_FREE,   10, 0, 0);
        add_row(MODE_FREE,   10, 65535, 0, 1, 0, ST_BAD_ARG);
        add_row(MODE_ADD,     0, 65530, 100);                   // runs past the end
        add_row(MODE_RESERVE, 0, 65535, 2);                     // second page outside
        add_row(MODE_FREE,    0, 65535, 0);
        add_row(MODE_ADD,     0, 16'hFFFF, 17'h1FFFF);
        add_row(MODE_RESERVE, 0, 2048, 3);
        add_row(MODE_FREE,    0, 2048, 0);                      // gives back a reserved page
        add_row(MODE_ALLOC,  10, 0, 0);
        add_row(MODE_ALLOC,   3, 0, 0);
        add_row(MODE_FREE,   10, 64512, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_request(rows[i]);
        for (int n = 0; n < RAND_ITEMS; n++) send_request(random_row());
        req_if.valid <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < DRAIN_CYC) begin
            @(posedge i_clk);
            drain++;
        end

        $display("Covered %0d requests (%0d directed), %0d responses checked",
                 req_sent, rows.size(), rsp_seen);
        $display("Allocations granted %0d, refused %0d; mismatches %0d",
                 alloc_ok, alloc_fail, mismatches);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
